// File: hdl/sapq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted-array min priority queue
// no dependencies

package sapq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 4;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_EMPTY,
        OP_ROTATE
    } op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // controller to datapath
    typedef struct packed {
        op_t  op;
        logic load;
        logic last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } sts_t;

endpackage

// File: hdl/sapq_datapath.sv
`timescale 1ns / 1ps
// sorted cell array, fill counter and result register
// depends on sapq_pkg

module sapq_datapath #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEF,
    parameter int FW    = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sapq_pkg::cmd_t                     cmd,
    input  logic signed [sapq_pkg::DATA_W-1:0] value,
    output sapq_pkg::sts_t                     sts,
    output logic [FW-1:0]                      fill,
    output sapq_pkg::out_item_t                result
);
    import sapq_pkg::*;

    logic signed [DATA_W-1:0] cell_reg  [DEPTH];
    logic signed [DATA_W-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]         ge;
    logic [FW-1:0]            fill_reg;
    logic [FW-1:0]            fill_next;
    out_item_t                result_reg;
    out_item_t                result_next;

    assign sts.full  = (fill_reg == FW'(DEPTH));
    assign sts.empty = (fill_reg == '0);
    assign fill      = fill_reg;
    assign result    = result_reg;

    // per-cell compare, shift and rotate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        // slot i holds a value greater than the new one, or is unused
        assign ge[i] = (FW'(i) >= fill_reg) || (cell_reg[i] > value);

        if (i == 0) begin : g_head
            always_comb
            begin
                cell_next[i] = cell_reg[i];
                case (cmd.op)
                    OP_INSERT: if (!sts.full && ge[i]) cell_next[i] = value;
                    OP_REMOVE: cell_next[i] = cell_reg[i + 1];
                    OP_ROTATE: cell_next[i] = cell_reg[i + 1];
                    default:   cell_next[i] = cell_reg[i];
                endcase
            end
        end else if (i == DEPTH - 1) begin : g_tail
            always_comb
            begin
                cell_next[i] = cell_reg[i];
                case (cmd.op)
                    OP_INSERT:
                        if (!sts.full && ge[i])
                            cell_next[i] = ge[i - 1] ? cell_reg[i - 1] : value;
                    OP_ROTATE: cell_next[i] = cell_reg[0];
                    default:   cell_next[i] = cell_reg[i];
                endcase
            end
        end else begin : g_mid
            always_comb
            begin
                cell_next[i] = cell_reg[i];
                case (cmd.op)
                    OP_INSERT:
                        if (!sts.full && ge[i])
                            cell_next[i] = ge[i - 1] ? cell_reg[i - 1] : value;
                    OP_REMOVE: cell_next[i] = cell_reg[i + 1];
                    OP_ROTATE: cell_next[i] = cell_reg[i + 1];
                    default:   cell_next[i] = cell_reg[i];
                endcase
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // fill counter
    always_comb
    begin
        fill_next = fill_reg;
        case (cmd.op)
            OP_INSERT: if (!sts.full)  fill_next = fill_reg + FW'(1);
            OP_REMOVE: if (!sts.empty) fill_next = fill_reg - FW'(1);
            default:   fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // result item select
    always_comb
    begin
        result_next.status = STAT_EMPTY;
        result_next.data   = '0;
        result_next.count  = '0;
        result_next.last   = 1'b1;
        case (cmd.op)
            OP_INSERT:
            begin
                result_next.status = sts.full ? STAT_FULL : STAT_OK;
                result_next.data   = value;
                result_next.count  = sts.full ? COUNT_W'(fill_reg)
                                              : COUNT_W'(fill_reg + FW'(1));
            end
            OP_REMOVE:
            begin
                if (!sts.empty)
                begin
                    result_next.status = STAT_OK;
                    result_next.data   = cell_reg[0];
                    result_next.count  = COUNT_W'(fill_reg - FW'(1));
                end
            end
            OP_ROTATE:
            begin
                result_next.status = STAT_OK;
                result_next.data   = cell_reg[0];
                result_next.count  = COUNT_W'(fill_reg);
                result_next.last   = cmd.last;
            end
            default:
            begin
                result_next.status = STAT_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            result_reg <= result_next;
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INSERT && !sts.full) |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("insert did not grow fill count");

    a_rotate_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ROTATE) |=> $stable(fill_reg))
        else $error("dump changed fill count");

endmodule

// File: hdl/sapq_ctrl.sv
`timescale 1ns / 1ps
// request decode, dump sequencer and output valid control
// depends on sapq_pkg

module sapq_ctrl #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEF,
    parameter int FW    = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    output logic           out_valid,
    input  logic           out_ready,
    input  sapq_pkg::sts_t sts,
    input  logic [FW-1:0]  fill,
    output sapq_pkg::cmd_t cmd
);
    import sapq_pkg::*;

    localparam int KW = $clog2(DEPTH);

    state_t        state_reg;
    state_t        state_next;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_free;
    logic          accept;
    logic          k_end;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign k_end     = (k_reg == KW'(DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (accept && req_type == REQ_DUMP && !sts.empty)
                    state_next = S_DUMP;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    k_next = k_reg + KW'(1);
                    if (k_end)
                    begin
                        k_next     = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.op   = OP_HOLD;
        cmd.load = 1'b0;
        cmd.last = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_INSERT:
                        begin
                            cmd.op   = OP_INSERT;
                            cmd.load = 1'b1;
                        end
                        REQ_REMOVE:
                        begin
                            cmd.op   = OP_REMOVE;
                            cmd.load = 1'b1;
                        end
                        REQ_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.op   = OP_EMPTY;
                                cmd.load = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.op = OP_HOLD;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    // full turn of the ring; emit only the stored slots
                    cmd.op   = OP_ROTATE;
                    cmd.load = (FW'(k_reg) < fill);
                    cmd.last = (FW'(k_reg) + FW'(1) == fill);
                end
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // checks
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> !in_ready)
        else $error("input taken during dump");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> out_free)
        else $error("result register overwritten");

endmodule

// File: hdl/sorted_array_min_priority_queue.sv
`timescale 1ns / 1ps
// top level of the sorted-array min priority queue
// depends on sapq_pkg, sapq_ctrl, sapq_datapath
//
//  channel  signals                      payload
//  -------  ---------------------------  ---------------------------------
//  in       in_valid / in_ready          in_item  (req_type, value)
//  out      out_valid / out_ready        out_item (status, data, count, last)
//
// on insert and remove, cells compare and shift in parallel and the result
// register loads at the accepting edge.
// a dump is started by the accepting cycle, then the cell ring rotates one
// slot per cycle while the result register is free, for a full turn, and
// emits one item per stored value.
// a new item is accepted when no dump runs and the result register is free
// or being taken; out_ready low stalls dump rotation.
// rst_n clears the fill count and control; cell contents are not reset.

module sorted_array_min_priority_queue #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sapq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sapq_pkg::out_item_t out_item
);
    import sapq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [FW-1:0] fill;

    sapq_ctrl #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (in_item.req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .fill      (fill),
        .cmd       (cmd)
    );

    sapq_datapath #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (in_item.value),
        .sts    (sts),
        .fill   (fill),
        .result (out_item)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for sorted_array_min_priority_queue: directed table, then random phases
// depends on sapq_pkg and the top level of the queue

module testbench;

    import sapq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // request code the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = DEPTH + 8;
    localparam int ITEMS_PER_PHASE = 101;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } table_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // typed expectation travels with the item it belongs to
    logic      typed_valid = 1'b0;
    out_item_t typed_result = '0;

    int sender_idle_pct = 0;
    int rcv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    // shadow copy of the sorted store and results still to come
    logic signed [DATA_W-1:0] shadow_keys [DEPTH];
    int                       shadow_fill = 0;
    out_item_t                due_results [$];

    table_row_t directed_rows [$];

    sorted_array_min_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t make_result(logic [1:0] status, logic [DATA_W-1:0] data,
                                              int count, logic last);
        out_item_t r;
        r.status = status;
        r.data   = data;
        r.count  = COUNT_W'(count);
        r.last   = last;
        return r;
    endfunction

    function automatic table_row_t row(logic [1:0] req, logic [DATA_W-1:0] value,
                                       logic typed, out_item_t result);
        table_row_t t;
        t.item.req_type = req;
        t.item.value    = value;
        t.typed         = typed;
        t.result        = result;
        return t;
    endfunction

    // apply one request to the shadow store and queue what it must produce
    function automatic void apply_request(in_item_t it, logic use_typed, out_item_t typed);
        logic signed [DATA_W-1:0] v;
        int                       i;
        int                       first;
        v = it.value;
        first = due_results.size();
        case (it.req_type)
            REQ_INSERT:
            begin
                if (shadow_fill >= DEPTH)
                    due_results.push_back(make_result(STAT_FULL, v, shadow_fill, 1'b1));
                else
                begin
                    // equal keys stay ahead of the newcomer
                    i = shadow_fill;
                    while (i > 0 && shadow_keys[i-1] > v)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        i--;
                    end
                    shadow_keys[i] = v;
                    shadow_fill++;
                    due_results.push_back(make_result(STAT_OK, v, shadow_fill, 1'b1));
                end
            end
            REQ_REMOVE:
            begin
                if (shadow_fill == 0)
                    due_results.push_back(make_result(STAT_EMPTY, '0, 0, 1'b1));
                else
                begin
                    v = shadow_keys[0];
                    for (i = 0; i + 1 < shadow_fill; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_fill--;
                    due_results.push_back(make_result(STAT_OK, v, shadow_fill, 1'b1));
                end
            end
            REQ_DUMP:
            begin
                if (shadow_fill == 0)
                    due_results.push_back(make_result(STAT_EMPTY, '0, 0, 1'b1));
                else
                    for (i = 0; i < shadow_fill; i++)
                        due_results.push_back(make_result(STAT_OK, shadow_keys[i], shadow_fill,
                                                          i + 1 == shadow_fill));
            end
            default:
            begin
                // ignored request, nothing comes back
            end
        endcase
        if (use_typed && due_results.size() > first)
            due_results[first] = typed;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // prediction on accepted items, comparison on accepted results
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                apply_request(in_item, typed_valid, typed_result);
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got data %0d",
                             $time, int'(out_item.data));
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", int'(want.status), int'(out_item.status));
                    check_field("data", int'(want.data), int'(out_item.data));
                    check_field("count", int'(want.count), int'(out_item.count));
                    check_field("last", int'(want.last), int'(out_item.last));
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(in_item_t it, logic use_typed, out_item_t typed);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_item      <= it;
        typed_valid  <= use_typed;
        typed_result <= typed;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off the sender until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return 32'($urandom_range(8)) - 32'd4;
            1: return $urandom_range(1) ? MAX_VAL - 32'($urandom_range(2))
                                        : MIN_VAL + 32'($urandom_range(2));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_request(int insert_pct);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return REQ_UNUSED;
        if (r < 12)
            return REQ_DUMP;
        return ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
    endfunction

    initial
    begin : stimulus
        in_item_t stim;
        int       n;
        int       insert_pct;
        int       idle_by_phase [4];
        int       stall_by_phase [4];

        idle_by_phase  = '{0, 53, 0, 12};
        stall_by_phase = '{0, 0, 53, 12};
        insert_pct = 50;

        // directed table: empty cases, extremes, ties, full store, ignored code
        directed_rows.push_back(row(REQ_REMOVE, 0, 1, make_result(STAT_EMPTY, 0, 0, 1)));
        directed_rows.push_back(row(REQ_DUMP, 0, 1, make_result(STAT_EMPTY, 0, 0, 1)));
        directed_rows.push_back(row(REQ_UNUSED, 32'hFFFF_FFFF, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, MAX_VAL, 1, make_result(STAT_OK, MAX_VAL, 1, 1)));
        directed_rows.push_back(row(REQ_INSERT, MIN_VAL, 1, make_result(STAT_OK, MIN_VAL, 2, 1)));
        directed_rows.push_back(row(REQ_INSERT, 32'd0, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, 32'hFFFF_FFFF, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, 32'd0, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, 32'd1, 0, '0));
        directed_rows.push_back(row(REQ_DUMP, 0, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, 32'd5, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, MAX_VAL, 0, '0));
        directed_rows.push_back(row(REQ_INSERT, 32'd42, 1, make_result(STAT_FULL, 42, 8, 1)));
        directed_rows.push_back(row(REQ_INSERT, MIN_VAL, 1, make_result(STAT_FULL, MIN_VAL, 8, 1)));
        directed_rows.push_back(row(REQ_DUMP, 0, 0, '0));
        directed_rows.push_back(row(REQ_UNUSED, 32'h5555_AAAA, 0, '0));
        directed_rows.push_back(row(REQ_REMOVE, 0, 1, make_result(STAT_OK, MIN_VAL, 7, 1)));
        for (n = 0; n < DEPTH - 1; n++)
            directed_rows.push_back(row(REQ_REMOVE, 32'hAAAA_5555, 0, '0));
        directed_rows.push_back(row(REQ_REMOVE, 0, 1, make_result(STAT_EMPTY, 0, 0, 1)));

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_by_phase[p];
            rcv_stall_pct   = stall_by_phase[p];

            if (p == 0)
            begin
                foreach (directed_rows[k])
                    send_item(directed_rows[k].item, directed_rows[k].typed,
                              directed_rows[k].result);
                drain_results();
            end

            // random traffic, tilted toward filling or draining in stretches
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                if (n % 20 == 0)
                    case ($urandom_range(2))
                        0: insert_pct = 85;
                        1: insert_pct = 50;
                        default: insert_pct = 20;
                    endcase
                stim.req_type = pick_request(insert_pct);
                stim.value    = pick_value();
                send_item(stim, 1'b0, '0);
                if (stim.req_type != REQ_UNUSED)
                    n++;
            end
            drain_results();
        end

        // let anything still in flight show up
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
